/* design/named_region_map_allocator_defines.svh */
// Assertion macros shared by the region map allocator RTL.
`ifndef NAMED_REGION_MAP_ALLOCATOR_DEFINES_SVH
`define NAMED_REGION_MAP_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define NRMA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nrma: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define NRMA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nrma: next-cycle check failed");

`endif

/* design/nrma_pkg.sv */
// Shared constants and types for the named region map allocator.
package nrma_pkg;

   // Table and store geometry
   localparam int SLOT_COUNT  = 16;
   localparam int STORE_BYTES = 4096;
   localparam int SLOT_W      = $clog2(SLOT_COUNT);
   localparam int PTR_W       = $clog2(STORE_BYTES + 1);
   localparam int END_W       = PTR_W + 2;

   // Fixed field widths
   localparam int NAME_W = 8;
   localparam int OFF_W  = 12;
   localparam int SIZE_W = 13;
   localparam int GAP_W  = 8;
   localparam int STAT_W = 2;

   // Request codes
   localparam logic FUNC_SAVE = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   // Status codes
   localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
   localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [STAT_W-1:0] ST_NO_SPACE  = 2'd3;

   // Lookup result handed from cell to cell
   typedef struct packed {
      logic              hit;
      logic [OFF_W-1:0]  hit_off;
      logic [SLOT_W-1:0] hit_idx;
      logic              free_found;
      logic [SLOT_W-1:0] free_idx;
   } chain_type;

   // Claim broadcast to every cell
   typedef struct packed {
      logic              en;
      logic [NAME_W-1:0] name;
      logic [OFF_W-1:0]  off;
   } claim_type;

endpackage

/* design/nrma_cell.sv */
// One table slot: holds used bit, name and offset, and extends the lookup chain.
module nrma_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [nrma_pkg::SLOT_W-1:0] cell_idx,
   input  logic [nrma_pkg::NAME_W-1:0] key,
   input  logic                      prev_used,
   input  nrma_pkg::claim_type       claim,
   input  nrma_pkg::chain_type       chain_in,
   output nrma_pkg::chain_type       chain_out,
   output logic                      used
);

   logic                       used_ff, used_in;
   logic [nrma_pkg::NAME_W-1:0] name_ff, name_in;
   logic [nrma_pkg::OFF_W-1:0]  off_ff, off_in;
   logic                       match;
   logic                       free_here;

   // Slot matches the key; slot is the first free one in the fill order
   assign match     = used_ff && (name_ff == key);
   assign free_here = !used_ff && prev_used;
   assign used      = used_ff;

   // Pass the chain on, taking the first hit and first free slot
   always_comb begin
      chain_out = chain_in;
      if (!chain_in.hit && match) begin
         chain_out.hit     = 1'b1;
         chain_out.hit_off = off_ff;
         chain_out.hit_idx = cell_idx;
      end
      if (!chain_in.free_found && free_here) begin
         chain_out.free_found = 1'b1;
         chain_out.free_idx   = cell_idx;
      end
   end

   // Claim writes only the first free slot
   always_comb begin
      used_in = used_ff;
      name_in = name_ff;
      off_in  = off_ff;
      if (claim.en && free_here) begin
         used_in = 1'b1;
         name_in = claim.name;
         off_in  = claim.off;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
      end else begin
         used_ff <= used_in;
      end
   end

   // Payload, no reset
   always_ff @(posedge clock) begin
      name_ff <= name_in;
      off_ff  <= off_in;
   end

endmodule

/* design/named_region_map_allocator.sv */
// Top level: request staging, slot cell row, bump pointer and result register.
//
//   port group  dir  handshake         payload
//   req_*       in   req_valid/stall   func, cell_id, region_size
//   rsp_*       out  rsp_valid/stall   status, byte_offset, slot_index, newly_made
//   csr_*       in   csr_wr_en         wr_data (region gap)
//
// An accepted item sits in the stage register while the row of slot cells looks
// it up, and the result register loads the outcome when the stage advances. A new
// item is taken every cycle while the result side keeps up. The cell row and its
// claim write set the lookup path. Reset clears the used bits, the bump pointer
// and the gap. A stalled result holds the staged item and stalls input.
`include "named_region_map_allocator_defines.svh"

module named_region_map_allocator (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_func,
   input  logic [nrma_pkg::NAME_W-1:0] req_cell_id,
   input  logic [nrma_pkg::SIZE_W-1:0] req_region_size,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [nrma_pkg::STAT_W-1:0] rsp_status,
   output logic [nrma_pkg::OFF_W-1:0]  rsp_byte_offset,
   output logic [nrma_pkg::SLOT_W-1:0] rsp_slot_index,
   output logic                        rsp_newly_made,
   input  logic                        csr_wr_en,
   input  logic [nrma_pkg::GAP_W-1:0]  csr_wr_data
);

   // Staged request
   logic                        pend_vld_ff, pend_vld_in;
   logic                        pend_func_ff;
   logic [nrma_pkg::NAME_W-1:0] pend_id_ff;
   logic [nrma_pkg::SIZE_W-1:0] pend_size_ff;

   // Config and bump pointer
   logic [nrma_pkg::GAP_W-1:0]  gap_ff, gap_in;
   logic [nrma_pkg::PTR_W-1:0]  next_free_ff, next_free_in;

   // Result register
   logic                        rsp_vld_ff, rsp_vld_in;
   logic [nrma_pkg::STAT_W-1:0] rsp_status_ff, rsp_status_in;
   logic [nrma_pkg::OFF_W-1:0]  rsp_off_ff, rsp_off_in;
   logic [nrma_pkg::SLOT_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic                        rsp_made_ff, rsp_made_in;

   logic                        advance;
   logic                        do_claim;
   logic                        no_space;
   logic [nrma_pkg::END_W-1:0]  req_end;
   logic [nrma_pkg::END_W-1:0]  new_end;
   logic [nrma_pkg::SLOT_COUNT-1:0] used_vec;
   logic [nrma_pkg::SLOT_COUNT-1:0] prev_vec;
   logic [nrma_pkg::SLOT_COUNT-1:0] used_inc;
   int                          used_cnt;
   nrma_pkg::chain_type         chain_w [nrma_pkg::SLOT_COUNT+1];
   nrma_pkg::chain_type         look;
   nrma_pkg::claim_type         claim;

   // Handshake
   assign advance   = pend_vld_ff && (!rsp_vld_ff || !rsp_stall);
   assign req_stall = pend_vld_ff && !advance;

   // Row of slot cells; slot 0 always sees a used left neighbor
   assign prev_vec   = {used_vec[nrma_pkg::SLOT_COUNT-2:0], 1'b1};
   assign chain_w[0] = '0;

   for (genvar i = 0; i < nrma_pkg::SLOT_COUNT; i++) begin : g_cell
      nrma_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_idx  (nrma_pkg::SLOT_W'(i)),
         .key       (pend_id_ff),
         .prev_used (prev_vec[i]),
         .claim     (claim),
         .chain_in  (chain_w[i]),
         .chain_out (chain_w[i+1]),
         .used      (used_vec[i])
      );
   end

   assign look = chain_w[nrma_pkg::SLOT_COUNT];

   // Space check for a new region at the bump pointer
   assign req_end  = nrma_pkg::END_W'(next_free_ff) + nrma_pkg::END_W'(pend_size_ff);
   assign new_end  = req_end + nrma_pkg::END_W'(gap_ff);
   assign no_space = (next_free_ff >= nrma_pkg::PTR_W'(nrma_pkg::STORE_BYTES)) ||
                     (req_end > nrma_pkg::END_W'(nrma_pkg::STORE_BYTES));

   // Result decode
   always_comb begin
      do_claim      = 1'b0;
      rsp_status_in = nrma_pkg::ST_OK;
      rsp_off_in    = '0;
      rsp_idx_in    = '0;
      rsp_made_in   = 1'b0;
      if (look.hit) begin
         rsp_off_in = look.hit_off;
         rsp_idx_in = look.hit_idx;
      end else if (pend_func_ff == nrma_pkg::FUNC_READ) begin
         rsp_status_in = nrma_pkg::ST_NOT_FOUND;
      end else if (!look.free_found) begin
         rsp_status_in = nrma_pkg::ST_FULL;
      end else if (no_space) begin
         rsp_status_in = nrma_pkg::ST_NO_SPACE;
      end else begin
         do_claim    = 1'b1;
         rsp_off_in  = next_free_ff[nrma_pkg::OFF_W-1:0];
         rsp_idx_in  = look.free_idx;
         rsp_made_in = 1'b1;
      end
   end

   // Claim broadcast
   always_comb begin
      claim.en   = advance && do_claim;
      claim.name = pend_id_ff;
      claim.off  = next_free_ff[nrma_pkg::OFF_W-1:0];
   end

   // Bump pointer saturates at the store size
   always_comb begin
      next_free_in = next_free_ff;
      if (claim.en) begin
         if (new_end > nrma_pkg::END_W'(nrma_pkg::STORE_BYTES)) begin
            next_free_in = nrma_pkg::PTR_W'(nrma_pkg::STORE_BYTES);
         end else begin
            next_free_in = new_end[nrma_pkg::PTR_W-1:0];
         end
      end
   end

   // Gap register
   assign gap_in = csr_wr_en ? csr_wr_data : gap_ff;

   // Stage and result valids
   always_comb begin
      pend_vld_in = pend_vld_ff;
      if (!req_stall) begin
         pend_vld_in = req_valid;
      end
      rsp_vld_in = rsp_vld_ff;
      if (advance) begin
         rsp_vld_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_vld_ff  <= 1'b0;
         rsp_vld_ff   <= 1'b0;
         gap_ff       <= '0;
         next_free_ff <= '0;
      end else begin
         pend_vld_ff  <= pend_vld_in;
         rsp_vld_ff   <= rsp_vld_in;
         gap_ff       <= gap_in;
         next_free_ff <= next_free_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         pend_func_ff <= req_func;
         pend_id_ff   <= req_cell_id;
         pend_size_ff <= req_region_size;
      end
      if (advance) begin
         rsp_status_ff <= rsp_status_in;
         rsp_off_ff    <= rsp_off_in;
         rsp_idx_ff    <= rsp_idx_in;
         rsp_made_ff   <= rsp_made_in;
      end
   end

   assign rsp_valid       = rsp_vld_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_byte_offset = rsp_off_ff;
   assign rsp_slot_index  = rsp_idx_ff;
   assign rsp_newly_made  = rsp_made_ff;

   // Terms for the checks
   assign used_inc = used_vec + nrma_pkg::SLOT_COUNT'(1);
   assign used_cnt = $countones(used_vec);

   // Checks
   `NRMA_ASSERT_SAME(a_made_is_ok, clock, reset, rsp_vld_ff && rsp_made_ff, rsp_status_ff == nrma_pkg::ST_OK)
   `NRMA_ASSERT_SAME(a_ptr_in_store, clock, reset, 1'b1, next_free_ff <= nrma_pkg::PTR_W'(nrma_pkg::STORE_BYTES))
   `NRMA_ASSERT_SAME(a_fill_contig, clock, reset, 1'b1, (used_vec & used_inc) == '0)
   `NRMA_ASSERT_NEXT(a_claim_adds_one, clock, reset, claim.en, used_cnt == $past(used_cnt) + 1)
   `NRMA_ASSERT_SAME(a_claim_no_hit, clock, reset, claim.en, !look.hit)

endmodule
